FILE: design/lpfc_pkg.sv
`default_nettype none
package lpfc_pkg;

  // Fixed field widths of the streaming words
  localparam int unsigned PAGE_FIELD_W = 16;
  localparam int unsigned FAULT_W      = 16;
  localparam int unsigned CFG_W        = 8;

  localparam logic [CFG_W-1:0]   CAP_RESET = 8'd4;
  localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

  // Strobes from the sequencer to every cell of the row
  typedef struct packed {
    logic cmp_en;  // latch match flag against the incoming page
    logic upd_en;  // apply the shift for this word
    logic hit;     // some cell matched
  } lpfc_ctl_t;

endpackage
`default_nettype wire

FILE: design/lpfc_cell.sv
`default_nettype none
module lpfc_cell #(
  parameter int unsigned PAGE_W = 16,
  parameter int unsigned OCC_W  = 8,
  parameter int unsigned IDX_W  = 7,
  parameter int unsigned IDX    = 0
) (
  input  wire logic               clk,
  input  wire lpfc_pkg::lpfc_ctl_t ctl,
  input  wire logic [OCC_W-1:0]   occ,
  input  wire logic [IDX_W-1:0]   hit_pos,
  input  wire logic [PAGE_W-1:0]  key,
  input  wire logic [PAGE_W-1:0]  shift_in,
  output logic      [PAGE_W-1:0]  page_q,
  output logic                    match_q,
  output logic      [PAGE_W-1:0]  evict_part
);
  import lpfc_pkg::*;

  logic [PAGE_W-1:0] page_r;
  logic              match_r;
  logic              live;
  logic              is_lru;
  logic              shift_en;

  // Cell 0 is the most recent entry; the entry at occ-1 is the LRU one
  assign live     = occ > OCC_W'(IDX);
  assign is_lru   = occ == OCC_W'(IDX + 1);
  assign shift_en = ctl.upd_en && (!ctl.hit || (IDX_W'(IDX) <= hit_pos));

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      match_r <= live && (page_r == key);
    end
    if (shift_en) begin
      page_r <= shift_in;
    end
  end

  assign page_q     = page_r;
  assign match_q    = match_r;
  assign evict_part = is_lru ? page_r : '0;

endmodule
`default_nettype wire

FILE: design/lru_page_fault_counter_core.sv
// LRU page replacement with a saturating page-fault counter.
// An accepted word is compared, then the row shifts and its result word is registered.
// No new word is taken before that shift, which waits on a full, untaken output register.
// The next input word is taken while an earlier result still waits in the output register.
// Reset (rst_n low, synchronous): list empty, fault count zero, frame capacity 4.
`default_nettype none
module lru_page_fault_counter_core #(
  parameter int unsigned MAX_FRAMES = 128,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input word
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [lpfc_pkg::PAGE_FIELD_W-1:0] in_tdata,   // [15:0] page_number
  input  wire logic [0:0]                        in_tuser,   // [0] sequence_start
  // result word
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [31:0]                            out_tdata,  // [15:0] fault_total,
                                                             // [31:16] evicted_page
  output logic [1:0]                             out_tuser,  // [0] was_hit, [1] evict_valid
  // frame capacity register
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lpfc_pkg::CFG_W-1:0]        cfg_data
);
  import lpfc_pkg::*;

  localparam int unsigned OCC_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned CAP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,  // ready for an input word
    ST_UPD  = 2'b10   // match flags latched, waiting to shift and publish
  } state_t;

  state_t             state_r, state_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [FAULT_W-1:0] fault_r, fault_nxt;
  logic [CFG_W-1:0]   cap_r;
  logic [PAGE_BITS-1:0] key_r;

  logic               out_valid_r;
  logic               out_hit_r, out_evict_r;
  logic [FAULT_W-1:0] out_fault_r;
  logic [PAGE_FIELD_W-1:0] out_victim_r;

  logic               in_acc;
  logic               upd_go;
  logic [OCC_W-1:0]   occ_view;
  logic [PAGE_BITS-1:0] in_key;
  lpfc_ctl_t          ctl;

  logic [MAX_FRAMES-1:0] match_vec;
  logic [PAGE_BITS-1:0]  page_vec  [MAX_FRAMES];
  logic [PAGE_BITS-1:0]  evict_vec [MAX_FRAMES];
  logic [IDX_W-1:0]      hit_pos;
  logic [PAGE_BITS-1:0]  victim;
  logic                  hit;
  logic                  evict;
  logic [CAP_W-1:0]      cap_eff;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign upd_go    = (state_r == ST_UPD) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  // Page bits beyond PAGE_BITS are dropped (or zero-filled for wide builds)
  assign in_key = PAGE_BITS'(in_tdata);

  // A sequence start empties the list before the compare, so the cells see
  // zero occupancy on that word.
  assign occ_view = (in_acc && in_tuser[0]) ? '0 : occ_r;

  assign ctl.cmp_en = in_acc;
  assign ctl.upd_en = upd_go;
  assign ctl.hit    = hit;

  // --------------------------------------------------------------------------
  // Row of cells: cell 0 most recent, shifting toward higher indexes
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    logic [PAGE_BITS-1:0] sin;
    if (g == 0) begin : g_head
      assign sin = key_r;
    end else begin : g_body
      assign sin = page_vec[g-1];
    end

    lpfc_cell #(
      .PAGE_W (PAGE_BITS),
      .OCC_W  (OCC_W),
      .IDX_W  (IDX_W),
      .IDX    (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ_view),
      .hit_pos    (hit_pos),
      .key        (in_key),
      .shift_in   (sin),
      .page_q     (page_vec[g]),
      .match_q    (match_vec[g]),
      .evict_part (evict_vec[g])
    );
  end

  // Match flags are one-hot (resident pages are unique); OR-encode the
  // position and collect the LRU cell's page.
  always_comb begin
    hit_pos = '0;
    victim  = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (match_vec[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
      end
      victim = victim | evict_vec[i];
    end
  end

  assign hit = |match_vec;

  // Capacity of zero acts as one frame; above the built depth it saturates
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (CAP_W'(cap_r) > CAP_W'(MAX_FRAMES)) begin
      cap_eff = CAP_W'(MAX_FRAMES);
    end else begin
      cap_eff = CAP_W'(cap_r);
    end
  end

  assign evict = !hit && (CAP_W'(occ_r) >= cap_eff) && (occ_r != '0);

  // --------------------------------------------------------------------------
  // Sequencer and counters
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    fault_nxt = fault_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_UPD;
          if (in_tuser[0]) begin
            occ_nxt   = '0;
            fault_nxt = '0;
          end
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
          if (!hit) begin
            if (fault_r != FAULT_MAX) begin
              fault_nxt = fault_r + FAULT_W'(1);
            end
            // eviction frees a slot that the new page takes right away
            if (!evict && (occ_r != OCC_W'(MAX_FRAMES))) begin
              occ_nxt = occ_r + OCC_W'(1);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      fault_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      fault_r <= fault_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= in_key;
    end
    if (upd_go) begin
      out_hit_r    <= hit;
      out_evict_r  <= evict;
      out_fault_r  <= fault_nxt;
      out_victim_r <= evict ? PAGE_FIELD_W'(victim) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_victim_r, out_fault_r};
  assign out_tuser  = {out_evict_r, out_hit_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(match_vec))
    else $error("more than one cell matched the page");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(MAX_FRAMES))
    else $error("occupancy beyond built depth");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evict_r))
    else $error("hit word reports an eviction");

  a_hit_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && hit) |=> (occ_r == $past(occ_r)))
    else $error("occupancy changed on a hit");

  a_miss_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && !hit) |=> (out_fault_r != '0))
    else $error("miss left fault count at zero");

endmodule
`default_nettype wire

FILE: tb/sv/tb_lru_page_fault_counter_core.sv
`timescale 1ns / 1ps
module tb_lru_page_fault_counter_core;
  import lpfc_pkg::*;

  localparam int unsigned MAX_FRAMES  = 128;
  localparam int unsigned PAGE_BITS   = 16;
  localparam int unsigned HOLD_CYCLES = 300;    // long output back-pressure stretch
  localparam int unsigned DRAIN_TAIL  = 8;      // margin after the last result word
  localparam int unsigned CYCLE_LIMIT = 40000;  // ~550 words under the heaviest stalls
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PEND_DEPTH  = 4;      // at most two words in flight

  typedef logic [PAGE_FIELD_W-1:0] page_t;

  // One result word, unpacked from out_tuser / out_tdata
  typedef struct packed {
    logic               was_hit;
    logic [FAULT_W-1:0] fault_total;
    logic               evict_valid;
    page_t              evicted_page;
  } page_outcome_t;

  // One directed reference; typed rows carry their own outcome, the rest use the predictor
  typedef struct packed {
    page_t         page;
    logic          seq_start;
    logic          typed;
    page_outcome_t outcome;
  } ref_row_t;

  localparam int unsigned N_DIRECTED = 18;

  // Walkthrough at the reset capacity of 4 frames (list shown LRU first).
  localparam ref_row_t DIRECTED_REFS [N_DIRECTED] = '{
    '{16'h0000, 1'b1, 1'b1, '{1'b0, 16'd1, 1'b0, 16'h0000}},  // fresh sequence, cold miss
    '{16'hFFFF, 1'b0, 1'b1, '{1'b0, 16'd2, 1'b0, 16'h0000}},  // all-ones page
    '{16'h0000, 1'b0, 1'b1, '{1'b1, 16'd2, 1'b0, 16'h0000}},  // hit: [FFFF 0000]
    '{16'h0001, 1'b0, 1'b1, '{1'b0, 16'd3, 1'b0, 16'h0000}},
    '{16'h0002, 1'b0, 1'b1, '{1'b0, 16'd4, 1'b0, 16'h0000}},  // frames now full
    '{16'h0003, 1'b0, 1'b1, '{1'b0, 16'd5, 1'b1, 16'hFFFF}},  // evicts LRU page FFFF
    '{16'h0000, 1'b0, 1'b1, '{1'b1, 16'd5, 1'b0, 16'h0000}},  // hit on the LRU slot
    '{16'h0003, 1'b0, 1'b1, '{1'b1, 16'd5, 1'b0, 16'h0000}},  // hit in the middle
    '{16'h0003, 1'b0, 1'b1, '{1'b1, 16'd5, 1'b0, 16'h0000}},  // hit on the MRU slot
    '{16'h0005, 1'b0, 1'b1, '{1'b0, 16'd6, 1'b1, 16'h0001}},  // evicts 0001
    '{16'h8000, 1'b0, 1'b0, '0},
    '{16'h7FFF, 1'b0, 1'b0, '0},
    '{16'hAAAA, 1'b1, 1'b1, '{1'b0, 16'd1, 1'b0, 16'h0000}},  // restart: list emptied
    '{16'h5555, 1'b0, 1'b1, '{1'b0, 16'd2, 1'b0, 16'h0000}},
    '{16'hAAAA, 1'b1, 1'b1, '{1'b0, 16'd1, 1'b0, 16'h0000}},  // restart on a resident page
    '{16'hAAAA, 1'b0, 1'b1, '{1'b1, 16'd1, 1'b0, 16'h0000}},
    '{16'h5555, 1'b0, 1'b0, '0},
    '{16'hFFFF, 1'b1, 1'b1, '{1'b0, 16'd1, 1'b0, 16'h0000}}
  };

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  page_t             in_tdata   = '0;   // [15:0] page_number
  logic [0:0]        in_tuser   = '0;   // [0] sequence_start
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;         // [15:0] fault_total, [31:16] evicted_page
  logic [1:0]        out_tuser;         // [0] was_hit, [1] evict_valid
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data   = '0;

  lru_page_fault_counter_core #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: LRU list (entry 0 = least recent), fault count, capacity reg
  // ---------------------------------------------------------------------------
  page_t              lru_pages [MAX_FRAMES];
  int unsigned        resident    = 0;
  logic [FAULT_W-1:0] fault_count = '0;
  logic [CFG_W-1:0]   frame_cap   = CAP_RESET;

  // Pull one entry out and close the gap; younger entries slide toward LRU.
  function automatic void drop_page(input int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < resident; i++) lru_pages[i] = lru_pages[i + 1];
    resident--;
  endfunction

  function automatic page_outcome_t predict_reference(input page_t page, input logic seq_start);
    int unsigned   usable;
    int unsigned   i;
    int unsigned   hit_pos;
    page_outcome_t res;
    res     = '0;
    hit_pos = 0;
    if (seq_start) begin
      resident    = 0;
      fault_count = '0;
    end
    // zero capacity acts as one frame; anything over the built depth clamps
    usable = 32'(frame_cap);
    if (usable == 0) usable = 1;
    if (usable > MAX_FRAMES) usable = MAX_FRAMES;
    for (i = 0; i < resident; i++) begin
      if (!res.was_hit && lru_pages[i] == page) begin
        res.was_hit = 1'b1;
        hit_pos     = i;
      end
    end
    if (res.was_hit) begin
      drop_page(hit_pos);
    end else begin
      if (fault_count != FAULT_MAX) fault_count++;
      // capacity may sit below occupancy after a write: still evict only one
      if (resident >= usable && resident > 0) begin
        res.evict_valid  = 1'b1;
        res.evicted_page = lru_pages[0];
        drop_page(0);
      end
    end
    if (resident < MAX_FRAMES) begin
      lru_pages[resident] = page;
      resident++;
    end
    res.fault_total = fault_count;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: sampled at the edge, so values are the pre-edge ones
  // ---------------------------------------------------------------------------
  page_outcome_t pend_buf [PEND_DEPTH];  // one per accepted reference, oldest first
  int unsigned   pend_wr      = 0;
  int unsigned   pend_rd      = 0;
  int unsigned   rows_queued  = 0;       // directed rows handed to the driver
  int unsigned   rows_taken   = 0;       // directed rows already accepted
  int unsigned   mismatches   = 0;
  int unsigned   results_seen = 0;

  always @(posedge clk) begin
    page_outcome_t got;
    page_outcome_t want;
    if (rst_n) begin
      // result side first: a word leaving now always belongs to an older reference
      if (out_tvalid && out_tready) begin
        got = {out_tuser[0], out_tdata[15:0], out_tuser[1], out_tdata[31:16]};
        if (pend_wr == pend_rd) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result word %0d with nothing outstanding: %s hit=%0b faults=%0d",
                     results_seen, "got", got.was_hit, got.fault_total,
                     " evict=%0b page=%h", got.evict_valid, got.evicted_page);
        end else begin
          want = pend_buf[pend_rd % PEND_DEPTH];
          pend_rd++;
          if (got.was_hit !== want.was_hit || got.fault_total !== want.fault_total ||
              got.evict_valid !== want.evict_valid ||
              got.evicted_page !== want.evicted_page) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"result word %0d: exp hit=%0b faults=%0d evict=%0b page=%h,",
                        " got hit=%0b faults=%0d evict=%0b page=%h"},
                       results_seen, want.was_hit, want.fault_total, want.evict_valid,
                       want.evicted_page, got.was_hit, got.fault_total, got.evict_valid,
                       got.evicted_page);
          end
        end
        results_seen++;
      end
      // predictor always advances; a typed directed row overrides its outcome
      if (in_tvalid && in_tready) begin
        want = predict_reference(in_tdata, in_tuser[0]);
        if (rows_taken < rows_queued) begin
          if (DIRECTED_REFS[rows_taken].typed) want = DIRECTED_REFS[rows_taken].outcome;
          rows_taken++;
        end
        pend_buf[pend_wr % PEND_DEPTH] = want;
        pend_wr++;
      end
      if (cfg_valid && cfg_ready) frame_cap = cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side ready: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int unsigned rcv_stall = 0;   // percent of cycles with out_tready low
  int unsigned hold_seq  = 0;   // bumped by the stimulus to request a hold-off
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_seen  <= hold_seq;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_stall);
    end
  end

  // Watchdog
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int unsigned snd_idle  = 0;   // percent of cycles the sender holds off
  page_t       pool_base = '0;  // base of the working set for random pages

  // Offer one reference word; returns at the edge it was taken.
  task automatic send_ref(input page_t page, input logic seq_start);
    if ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= page;
    in_tuser  <= seq_start;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every result word has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pend_wr != pend_rd) @(posedge clk);
  endtask

  // Idle the block, write the capacity register, set the idling mix.
  task automatic start_phase(input logic [CFG_W-1:0] cap, input int unsigned snd,
                             input int unsigned rcv);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    snd_idle  = snd;
    rcv_stall = rcv;
  endtask

  // Mostly a small working set so hits land at every list position; the rest
  // are full-range pages and the all-zeros / all-ones extremes.
  task automatic run_refs(input int unsigned count, input int unsigned pool,
                          input int unsigned start_pct);
    int unsigned k;
    page_t       page;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1:    page = page_t'($urandom);
        2:       page = ($urandom_range(0, 1) != 0) ? page_t'('1) : page_t'(0);
        default: page = pool_base + page_t'($urandom_range(0, pool - 1));
      endcase
      send_ref(page, $urandom_range(0, 99) < start_pct);
    end
  endtask

  initial begin
    int unsigned n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed walkthrough at the reset capacity, no idling
    for (n = 0; n < N_DIRECTED; n++) begin
      rows_queued = n + 1;
      send_ref(DIRECTED_REFS[n].page, DIRECTED_REFS[n].seq_start);
    end

    pool_base = page_t'($urandom);
    start_phase(8'd3, 0, 0);
    run_refs(80, 6, 3);

    // fill a deep list with the sender idling most of the time
    start_phase(8'd128, 75, 0);
    run_refs(80, 150, 0);

    // capacity now well below occupancy: misses swap one page, list stays long
    start_phase(8'd2, 0, 75);
    run_refs(80, 8, 0);

    // above the built depth: clamps to 128
    pool_base = page_t'($urandom);
    start_phase(8'd255, 36, 36);
    run_refs(80, 160, 2);

    start_phase(8'd1, 0, 0);
    run_refs(50, 3, 3);

    // back-pressure: result side holds off while the sender keeps pushing,
    // so the output register fills and in_tready drops
    start_phase(8'd129, 0, 0);
    hold_seq <= hold_seq + 1;
    run_refs(40, 140, 0);

    start_phase(8'($urandom_range(5, 127)), 36, 36);
    run_refs(70, 40, 2);

    start_phase(CAP_RESET, 75, 75);
    run_refs(40, 6, 3);

    // zero capacity (one frame): every page faults, and each after the first evicts the one before
    start_phase(8'd0, 0, 0);
    for (n = 0; n < 16; n++) send_ref(page_t'(n), n == 0);

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
